FILE: design/wheel_speed_pi_controller_top_macros.svh
// Assertion macros for the wheel speed PI controller.
// Used by the top level; expects clk and arst_n in scope.
`ifndef WHEEL_SPEED_PI_CONTROLLER_TOP_MACROS_SVH
`define WHEEL_SPEED_PI_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wspc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wspc assertion failed");

`endif

FILE: design/wspc_pkg.sv
// Shared types and constants for the wheel speed PI controller.
// No dependencies.
`timescale 1ns / 1ps
package wspc_pkg;

	localparam int TICK_WIDTH = 32;

	// Serial multiplier: multiplicand and multiplier widths.
	localparam int MUL_A_W = 49;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

	// Bits of the dividend for the divide by eleven.
	localparam int DIV_W = 45;
	localparam int CNT_W = $clog2(DIV_W);

	localparam int DUTY_LIMIT = 25600;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	typedef enum logic [2:0] {
		REG_KP_GAIN       = 3'd0,
		REG_KI_GAIN       = 3'd1,
		REG_SAMPLE_PERIOD = 3'd2,
		REG_SAMPLE_RATE   = 3'd3,
		REG_FILTER_WEIGHT = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RAW,
		ST_TAKE_RAW,
		ST_MUL_FILT,
		ST_TAKE_FILT,
		ST_DIV,
		ST_TAKE_DIV,
		ST_MUL_INT,
		ST_TAKE_INT,
		ST_MUL_KP,
		ST_TAKE_KP,
		ST_MUL_KI,
		ST_TAKE_KI,
		ST_FINISH
	} state_t;

endpackage

FILE: design/wheel_speed_pi_controller_top.sv
// Wheel speed PI controller, top level.
// Depends on wspc_pkg and wheel_speed_pi_controller_top_macros.svh.
`timescale 1ns / 1ps
`include "wheel_speed_pi_controller_top_macros.svh"

// Each input word carries an absolute encoder count and a reference speed in
// 1/256 rpm. The block differentiates the count, scales it by the sample rate,
// low-pass filters it, converts it to rpm and runs a PI law whose output is a
// duty cycle in 1/256 percent, clipped to plus or minus 100 percent with a flag
// marking the clip. All arithmetic goes through one shift-and-add multiplier
// that retires one multiplier bit per cycle and a divide-by-eleven unit that
// retires one quotient bit per cycle. One word runs five multiplies and one
// divide, each followed by a take state, then a finish state that loads the
// output register. The next word can be accepted in the cycle after the current
// one reaches the output register, and not before, so words never overlap.
// Configuration registers are written through a simple write port and should
// only be changed while the block is idle.
module wheel_speed_pi_controller_top
	import wspc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] tick_count,
	input  logic signed [21:0] reference_rpm,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] duty_cycle,
	output logic signed [23:0] measured_rpm,
	output logic               output_clipped
);

	// Configuration registers.
	logic signed [31:0] kp_q, ki_q;
	logic [31:0]        period_q;
	logic [19:0]        rate_q;
	logic [16:0]        weight_q;

	// Controller state.
	logic [TICK_WIDTH-1:0] prev_q;
	logic signed [47:0]    fs_q;
	logic signed [47:0]    integ_q;

	// Per-word working registers.
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [21:0]  ref_q;
	logic signed [23:0]  rpm_q;
	logic signed [24:0]  err_q;
	logic signed [48:0]  term_q;
	logic signed [MUL_A_W-1:0] mul_a_q;
	logic signed [MUL_A_W:0]   acc_q;
	logic [MUL_B_W-1:0]        mul_b_q;
	logic [DIV_W-1:0]          div_q;
	logic [3:0]                rem_q;
	logic                      neg_q;

	// Output register.
	logic                out_valid_q;
	logic signed [15:0]  duty_q;
	logic signed [23:0]  rpm_out_q;
	logic                clip_q;

	logic in_fire, mul_state, mul_last, div_last, load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign mul_state = (state_q == ST_MUL_RAW) || (state_q == ST_MUL_FILT) ||
		(state_q == ST_MUL_INT) || (state_q == ST_MUL_KP) || (state_q == ST_MUL_KI);
	assign mul_last  = (cnt_q == CNT_W'(MUL_B_W - 1));
	assign div_last  = (cnt_q == CNT_W'(DIV_W - 1));
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// One multiplier bit per cycle; the top bit carries negative weight.
	logic signed [MUL_A_W:0] addend, mul_sum;
	always_comb begin
		if (!mul_b_q[0]) begin
			addend = '0;
		end else if (mul_last) begin
			addend = -(MUL_A_W+1)'(mul_a_q);
		end else begin
			addend = (MUL_A_W+1)'(mul_a_q);
		end
		mul_sum = acc_q + addend;
	end

	// Full product after the last step.
	logic signed [PROD_W-1:0] prod;
	assign prod = $signed({acc_q, mul_b_q});

	// Divide step: one quotient bit of the magnitude divided by eleven.
	logic [4:0] div_trial;
	logic       div_bit;
	assign div_trial = {rem_q, div_q[DIV_W-1]};
	assign div_bit   = (div_trial >= 5'd11);

	// Raw speed: saturate to 32 bits, then form delta against the filter.
	logic signed [31:0] raw_sat;
	logic signed [48:0] delta;
	logic [16:0]        weight_eff;
	always_comb begin
		if (prod > PROD_W'(64'sd2147483647)) begin
			raw_sat = 32'sh7fffffff;
		end else if (prod < -PROD_W'(64'sd2147483648)) begin
			raw_sat = 32'sh80000000;
		end else begin
			raw_sat = prod[31:0];
		end
		delta = 49'($signed({raw_sat, 16'd0})) - 49'(fs_q);
		weight_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	end

	// Filter update and the scaling by thirty ahead of the divide.
	logic signed [50:0] fs_sum;
	logic signed [47:0] fs_new;
	logic signed [52:0] fs30;
	logic [52:0]        fs30_mag;
	always_comb begin
		fs_sum = 51'(fs_q) + 51'($signed(prod[65:16]));
		if (fs_sum > 51'sh7fffffffffff) begin
			fs_new = 48'sh7fffffffffff;
		end else if (fs_sum < -51'sh800000000000) begin
			fs_new = 48'sh800000000000;
		end else begin
			fs_new = fs_sum[47:0];
		end
		fs30 = (53'(fs_new) <<< 5) - (53'(fs_new) <<< 1);
		fs30_mag = fs30[52] ? 53'(-fs30) : 53'(fs30);
	end

	// Rpm from the quotient, truncated toward zero and saturated.
	logic signed [23:0] rpm_new;
	logic signed [24:0] err_new;
	always_comb begin
		if (!neg_q) begin
			rpm_new = (div_q > DIV_W'(8388607)) ? 24'sh7fffff : $signed(div_q[23:0]);
		end else begin
			rpm_new = (div_q > DIV_W'(8388608)) ? 24'sh800000 : -$signed(div_q[23:0]);
		end
		err_new = 25'(ref_q) - 25'(rpm_new);
	end

	// Integrator update with saturation.
	logic signed [49:0] integ_sum;
	logic signed [47:0] integ_new;
	always_comb begin
		integ_sum = 50'(integ_q) + 50'($signed(prod[64:16]));
		if (integ_sum > 50'sh7fffffffffff) begin
			integ_new = 48'sh7fffffffffff;
		end else if (integ_sum < -50'sh800000000000) begin
			integ_new = 48'sh800000000000;
		end else begin
			integ_new = integ_sum[47:0];
		end
	end

	// PI sum and clip.
	logic signed [50:0] pi_sum;
	logic signed [15:0] duty_new;
	logic               clip_new;
	always_comb begin
		pi_sum = 51'(term_q) + 51'($signed(prod[81:32]));
		clip_new = (pi_sum > 51'(DUTY_LIMIT)) || (pi_sum < -51'(DUTY_LIMIT));
		if (pi_sum > 51'(DUTY_LIMIT)) begin
			duty_new = 16'(DUTY_LIMIT);
		end else if (pi_sum < -51'(DUTY_LIMIT)) begin
			duty_new = -16'(DUTY_LIMIT);
		end else begin
			duty_new = pi_sum[15:0];
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_fire) state_d = ST_MUL_RAW;
			ST_MUL_RAW:   if (mul_last) state_d = ST_TAKE_RAW;
			ST_TAKE_RAW:  state_d = ST_MUL_FILT;
			ST_MUL_FILT:  if (mul_last) state_d = ST_TAKE_FILT;
			ST_TAKE_FILT: state_d = ST_DIV;
			ST_DIV:       if (div_last) state_d = ST_TAKE_DIV;
			ST_TAKE_DIV:  state_d = ST_MUL_INT;
			ST_MUL_INT:   if (mul_last) state_d = ST_TAKE_INT;
			ST_TAKE_INT:  state_d = ST_MUL_KP;
			ST_MUL_KP:    if (mul_last) state_d = ST_TAKE_KP;
			ST_TAKE_KP:   state_d = ST_MUL_KI;
			ST_MUL_KI:    if (mul_last) state_d = ST_TAKE_KI;
			ST_TAKE_KI:   state_d = ST_FINISH;
			ST_FINISH:    if (load_out) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			ki_q     <= '0;
			period_q <= 32'd4294967;
			rate_q   <= 20'd1000;
			weight_q <= 17'd6554;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_GAIN:       kp_q     <= $signed(cfg_data);
				REG_KI_GAIN:       ki_q     <= $signed(cfg_data);
				REG_SAMPLE_PERIOD: period_q <= cfg_data;
				REG_SAMPLE_RATE:   rate_q   <= cfg_data[19:0];
				REG_FILTER_WEIGHT: weight_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Controller state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			fs_q    <= '0;
			integ_q <= '0;
		end else begin
			if (in_fire) prev_q <= tick_count[TICK_WIDTH-1:0];
			if (state_q == ST_TAKE_FILT) fs_q <= fs_new;
			if (state_q == ST_TAKE_INT) integ_q <= integ_new;
		end
	end

	// Datapath and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (mul_state || (state_q == ST_DIV)) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_state) begin
			acc_q   <= {mul_sum[MUL_A_W], mul_sum[MUL_A_W:1]};
			mul_b_q <= {mul_sum[0], mul_b_q[MUL_B_W-1:1]};
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ref_q   <= reference_rpm;
					mul_a_q <= MUL_A_W'($signed(tick_count[TICK_WIDTH-1:0] - prev_q));
					mul_b_q <= MUL_B_W'(rate_q);
					acc_q   <= '0;
				end
			end
			ST_TAKE_RAW: begin
				mul_a_q <= delta;
				mul_b_q <= MUL_B_W'(weight_eff);
				acc_q   <= '0;
			end
			ST_TAKE_FILT: begin
				neg_q <= fs30[52];
				div_q <= fs30_mag[52:8];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_bit ? 4'(div_trial - 5'd11) : div_trial[3:0];
				div_q <= {div_q[DIV_W-2:0], div_bit};
			end
			ST_TAKE_DIV: begin
				rpm_q   <= rpm_new;
				err_q   <= err_new;
				mul_a_q <= MUL_A_W'(period_q);
				mul_b_q <= MUL_B_W'(err_new);
				acc_q   <= '0;
			end
			ST_TAKE_INT: begin
				mul_a_q <= MUL_A_W'(kp_q);
				mul_b_q <= MUL_B_W'(err_q);
				acc_q   <= '0;
			end
			ST_TAKE_KP: begin
				term_q  <= $signed(prod[64:16]);
				mul_a_q <= MUL_A_W'(integ_q);
				mul_b_q <= ki_q;
				acc_q   <= '0;
			end
			ST_TAKE_KI: begin
				duty_q <= duty_new;
				clip_q <= clip_new;
			end
			default: ;
		endcase
	end

	// Output register: the finished word waits here while the next is accepted.
	logic signed [15:0] duty_res_q;
	logic signed [23:0] rpm_res_q;
	logic               clip_res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_res_q <= duty_q;
			rpm_res_q  <= rpm_q;
			clip_res_q <= clip_q;
		end
	end

	assign rpm_out_q      = rpm_res_q;
	assign out_valid      = out_valid_q;
	assign duty_cycle     = duty_res_q;
	assign measured_rpm   = rpm_out_q;
	assign output_clipped = clip_res_q;

	`WSPC_ASSERT_NEXT(a_start_mul, in_fire, state_q == ST_MUL_RAW && cnt_q == '0)
	`WSPC_ASSERT_NOW(a_mul_count, mul_state, cnt_q <= CNT_W'(MUL_B_W - 1))
	`WSPC_ASSERT_NOW(a_duty_range, state_q == ST_TAKE_KI,
		duty_new <= 16'sd25600 && duty_new >= -16'sd25600)
	`WSPC_ASSERT_NOW(a_clip_edge, state_q == ST_TAKE_KI && clip_new,
		duty_new == 16'sd25600 || duty_new == -16'sd25600)

endmodule

FILE: bench/tb_wheel_speed_pi_controller_top.sv
// Self-checking testbench for the wheel speed PI controller top level.
// Depends on wspc_pkg and the design files; drives directed and random words.
`timescale 1ns / 1ps

module tb_wheel_speed_pi_controller_top;
	import wspc_pkg::*;

	// The cycle limit leaves a wide margin over the work of the whole run
	// for stalls on both sides.
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int IDLE_PCT = 27;
	localparam int RANDOM_PHASES = 10;
	localparam int WORDS_PER_PHASE = 150;
	// Register index beyond the last register; the block must ignore it.
	localparam logic [2:0] UNUSED_INDEX = 3'd5;
	localparam longint S48_MAX = 64'sd140737488355327;
	localparam longint S48_MIN = -S48_MAX - 1;

	typedef struct {
		logic signed [15:0] duty;
		logic signed [23:0] rpm;
		logic               clip;
	} pi_result_t;

	// One row of the directed table. Where typed is set, the expected
	// result is written in by hand instead of taken from the predictor.
	typedef struct {
		logic signed [31:0] ticks;
		logic signed [21:0] ref_rpm;
		bit                 typed;
		pi_result_t         res;
	} speed_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] tick_count = '0;
	logic signed [21:0] reference_rpm = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] duty_cycle;
	logic signed [23:0] measured_rpm;
	logic               output_clipped;

	// Shadow copy of the configuration and of the controller state.
	longint     kp_shadow, ki_shadow, period_shadow, rate_shadow, weight_shadow;
	logic [31:0] last_ticks;
	longint     speed_acc, integ_acc;

	pi_result_t expected_duty_q[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	bit         no_idle = 1'b0;

	wheel_speed_pi_controller_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.tick_count(tick_count), .reference_rpm(reference_rpm),
		.out_valid(out_valid), .out_ready(out_ready),
		.duty_cycle(duty_cycle), .measured_rpm(measured_rpm),
		.output_clipped(output_clipped)
	);

	always #2 clk = ~clk;

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Runs one control tick on the shadow state and returns its result.
	function automatic pi_result_t control_tick(logic [31:0] ticks, logic signed [21:0] ref_rpm);
		pi_result_t r;
		longint diff, raw, w, rpm, err, sum;
		logic signed [127:0] a, b, p;
		diff = longint'(signed'(ticks - last_ticks));
		last_ticks = ticks;
		raw = clamp(diff * rate_shadow, -64'sd2147483648, 64'sd2147483647) * 65536;
		w = (weight_shadow > 65536) ? 65536 : weight_shadow;
		// Filter step: floor of weight times the gap, over 2^16.
		a = w;
		b = raw - speed_acc;
		p = (a * b) >>> 16;
		speed_acc = clamp(speed_acc + longint'(p), S48_MIN, S48_MAX);
		// Division truncates toward zero, as the rpm conversion requires.
		rpm = clamp((speed_acc * 30) / 2816, -64'sd8388608, 64'sd8388607);
		err = longint'(ref_rpm) - rpm;
		integ_acc = clamp(integ_acc + ((err * period_shadow) >>> 16), S48_MIN, S48_MAX);
		a = ki_shadow;
		b = integ_acc;
		p = (a * b) >>> 32;
		sum = ((kp_shadow * err) >>> 16) + longint'(p);
		r.clip = (sum > DUTY_LIMIT) || (sum < -DUTY_LIMIT);
		r.duty = 16'(clamp(sum, -DUTY_LIMIT, DUTY_LIMIT));
		r.rpm = 24'(rpm);
		return r;
	endfunction

	// Register writes happen only with nothing outstanding, plus a pause
	// so the block has surely returned to idle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		while (expected_duty_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_KP_GAIN:       kp_shadow = longint'(signed'(value));
			REG_KI_GAIN:       ki_shadow = longint'(signed'(value));
			REG_SAMPLE_PERIOD: period_shadow = longint'(value);
			REG_SAMPLE_RATE:   rate_shadow = longint'(value[19:0]);
			REG_FILTER_WEIGHT: weight_shadow = longint'(value[16:0]);
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] period,
			logic [31:0] rate, logic [31:0] weight);
		write_reg(REG_KP_GAIN, kp);
		write_reg(REG_KI_GAIN, ki);
		write_reg(REG_SAMPLE_PERIOD, period);
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_FILTER_WEIGHT, weight);
	endtask

	// Offers one word and records its expected result once it is taken.
	task automatic send_word(logic [31:0] ticks, logic signed [21:0] ref_rpm,
			bit typed, pi_result_t res);
		pi_result_t predicted;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) @(negedge clk);
		in_valid = 1'b1;
		tick_count = ticks;
		reference_rpm = ref_rpm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = control_tick(ticks, ref_rpm);
		expected_duty_q.push_back(typed ? res : predicted);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// The receiver stalls at random except during the no-idle stretch.
	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		pi_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_duty_q.size() == 0) begin
				$display("%0t: unexpected result duty=%0d rpm=%0d clip=%0b", $time,
					duty_cycle, measured_rpm, output_clipped);
				fail_count <= fail_count + 1;
			end else begin
				exp_r = expected_duty_q.pop_front();
				if (duty_cycle !== exp_r.duty || measured_rpm !== exp_r.rpm ||
						output_clipped !== exp_r.clip) begin
					$display("%0t: expected duty=%0d rpm=%0d clip=%0b, got duty=%0d rpm=%0d clip=%0b",
						$time, exp_r.duty, exp_r.rpm, exp_r.clip,
						duty_cycle, measured_rpm, output_clipped);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[wheel_speed_pi_controller_top] ERROR");
			$finish;
		end
	end

	initial begin
		speed_row_t table_rows[$];
		pi_result_t zero_res;
		logic [31:0] ticks;
		logic signed [21:0] ref_rpm;
		logic [31:0] kp, ki, period, rate, weight;
		int step;

		kp_shadow = 0;
		ki_shadow = 0;
		period_shadow = 4294967;
		rate_shadow = 1000;
		weight_shadow = 6554;
		last_ticks = '0;
		speed_acc = 0;
		integ_acc = 0;
		zero_res = '{duty: '0, rpm: '0, clip: 1'b0};

		// With both gains at zero after reset the duty is always zero, and a
		// count of zero keeps the measured speed at zero.
		table_rows = '{
			'{32'sd0, 22'sd0, 1'b1, zero_res},
			'{32'sd0, 22'sd2097151, 1'b1, zero_res},
			'{32'sd0, -22'sd2097152, 1'b1, zero_res},
			'{32'sd1000, 22'sd0, 1'b0, zero_res},
			'{32'sd2000, 22'sd5000, 1'b0, zero_res},
			'{32'h7fffffff, 22'sd0, 1'b0, zero_res},
			'{32'h80000000, 22'sd0, 1'b0, zero_res},
			'{32'hffffffff, -22'sd1, 1'b0, zero_res},
			'{32'h00000005, 22'sd2097151, 1'b0, zero_res}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset configuration, including counter wrap.
		foreach (table_rows[i])
			send_word(table_rows[i].ticks, table_rows[i].ref_rpm, table_rows[i].typed,
				table_rows[i].res);

		// Largest kp and period, most negative ki, a rate of 1000000 and a weight above one.
		write_all(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd1000000, 32'h1ffff);
		write_reg(UNUSED_INDEX, 32'h12345678);
		send_word(32'h00001000, 22'sd2097151, 1'b0, zero_res);
		send_word(32'h00001000, -22'sd2097152, 1'b0, zero_res);
		send_word(32'h80001000, 22'sd0, 1'b0, zero_res);
		send_word(32'h00001000, 22'sd100, 1'b0, zero_res);
		send_word(32'h00001001, 22'sd0, 1'b0, zero_res);

		// Zero rate and period, smallest kp, largest ki and a zero filter weight.
		write_all(32'h80000000, 32'h7fffffff, 32'd0, 32'd0, 32'd0);
		send_word(32'h12345678, 22'sd2097151, 1'b0, zero_res);
		send_word(32'h00000000, -22'sd2097152, 1'b0, zero_res);
		send_word(32'h7fffffff, 22'sd1, 1'b0, zero_res);
		write_all(32'h00010000, 32'h00008000, 32'd1, 32'd1, 32'd65536);
		send_word(32'h00000010, 22'sd256, 1'b0, zero_res);
		send_word(32'hfffffff0, -22'sd256, 1'b0, zero_res);

		// Random phases. Most words follow a plausible encoder count with a
		// small step per tick, so the filter and the integrator settle; the
		// rest jump anywhere in the full field ranges.
		ticks = 32'h0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 1) begin
				kp = 32'h7fffffff; ki = 32'h7fffffff; period = 32'hffffffff;
				rate = 32'd1000000; weight = 32'd65536;
			end else if (phase == 2) begin
				kp = 32'h80000000; ki = 32'h80000000; period = 32'd1;
				rate = 32'd1; weight = 32'd0;
			end else begin
				kp = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 20));
				ki = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 18));
				if ($urandom_range(1)) begin
					kp = -kp;
					ki = -ki;
				end
				period = $urandom_range(1) ? 32'd4294967 : $urandom;
				rate = $urandom_range(1) ? 32'd1000 : 32'($urandom_range(1, 1000000));
				weight = 32'($urandom_range(131071));
			end
			write_all(kp, ki, period, rate, weight);
			no_idle = (phase == 4);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 80) begin
					step = int'($urandom_range(400)) - 200;
					ticks = ticks + 32'(step);
					ref_rpm = 22'(int'($urandom_range(1 << 18)) - (1 << 17));
				end else begin
					ticks = $urandom;
					ref_rpm = 22'($urandom);
				end
				send_word(ticks, ref_rpm, 1'b0, zero_res);
			end
			no_idle = 1'b0;
		end

		while (expected_duty_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("[wheel_speed_pi_controller_top] OK");
		end else begin
			$display("[wheel_speed_pi_controller_top] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/wspc_pkg.sv
design/wheel_speed_pi_controller_top.sv
bench/tb_wheel_speed_pi_controller_top.sv
